[hdl/tun_pkg.sv]
`default_nettype none
package tun_pkg;

    localparam int COORD_W    = 24;
    localparam int NORM_BITS  = 24;
    localparam int FRAC_SHIFT = 20;
    localparam int SQ_PAD     = 12;
    localparam int Q_BITS     = 15;
    localparam int OUT_W      = 16;
    localparam int OUT_ONE    = 16384;

    localparam int EW    = COORD_W + 1;
    localparam int PW    = 2 * EW;
    localparam int NW    = PW + 1;
    localparam int MW    = PW;
    localparam int BLW   = $clog2(MW + 1);
    localparam int SMW   = NORM_BITS;
    localparam int SQW   = 2 * SMW;
    localparam int SUMW  = SQW + 2;
    localparam int RADW  = SUMW + SQ_PAD;
    localparam int ROOTW = RADW / 2;
    localparam int NUMW  = SMW + FRAC_SHIFT + 1;
    localparam int SIDE_W = 3 * SMW + 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] norm_x;
        logic signed [OUT_W-1:0] norm_y;
        logic signed [OUT_W-1:0] norm_z;
        logic                    degenerate;
    } norm_out_t;

    typedef struct packed {
        logic [2:0][SMW-1:0] sm;
        logic [2:0]          neg;
        logic                degen;
    } side_t;

endpackage
`default_nettype wire

[hdl/tun_cross.sv]
`default_nettype none
module tun_cross
    import tun_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire tri_in_t            din,
    output logic                    out_valid,
    output logic [2:0][MW-1:0]      mag,
    output logic [2:0]              neg
);

    logic [3:0]                v_reg;
    logic signed [EW-1:0]      e1_reg [3];
    logic signed [EW-1:0]      e2_reg [3];
    logic signed [PW-1:0]      p_reg  [6];
    logic signed [NW-1:0]      n_reg  [3];
    logic [2:0][MW-1:0]        mag_reg;
    logic [2:0]                neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg[0] <= EW'(din.b_x) - EW'(din.a_x);
            e1_reg[1] <= EW'(din.b_y) - EW'(din.a_y);
            e1_reg[2] <= EW'(din.b_z) - EW'(din.a_z);
            e2_reg[0] <= EW'(din.c_x) - EW'(din.a_x);
            e2_reg[1] <= EW'(din.c_y) - EW'(din.a_y);
            e2_reg[2] <= EW'(din.c_z) - EW'(din.a_z);

            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e2_reg[1] * e1_reg[2];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e2_reg[2] * e1_reg[0];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e2_reg[0] * e1_reg[1];

            for (int i = 0; i < 3; i++) begin
                n_reg[i]   <= NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
                neg_reg[i] <= n_reg[i][NW-1];
                mag_reg[i] <= n_reg[i][NW-1] ? MW'(-n_reg[i]) : MW'(n_reg[i]);
            end
        end
    end

    assign out_valid = v_reg[3];
    assign mag       = mag_reg;
    assign neg       = neg_reg;

endmodule
`default_nettype wire

[hdl/tun_scale.sv]
`default_nettype none
module tun_scale
    import tun_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [2:0][MW-1:0] mag,
    input  wire logic [2:0]         neg,
    output logic                    out_valid,
    output logic [RADW-1:0]         rad,
    output side_t                   side
);

    logic [3:0]          v_reg;
    logic [MW-1:0]       orv;
    logic [BLW-1:0]      bl;
    logic [BLW-1:0]      s_reg;
    logic [2:0][MW-1:0]  mag_reg;
    logic [2:0]          neg5_reg, neg6_reg, neg7_reg, neg8_reg;
    logic                dg5_reg, dg6_reg, dg7_reg, dg8_reg;
    logic [2:0][SMW-1:0] sm6_reg, sm7_reg, sm8_reg;
    logic [2:0][SQW-1:0] sq_reg;
    logic [SUMW-1:0]     sum_reg;
    logic [MW-1:0]       shifted [3];

    assign orv = mag[0] | mag[1] | mag[2];

    // bit length of the largest magnitude
    always_comb begin
        bl = '0;
        for (int i = 0; i < MW; i++) begin
            if (orv[i]) bl = BLW'(i + 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = mag_reg[i] >> s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= (bl > BLW'(NORM_BITS)) ? bl - BLW'(NORM_BITS) : '0;
            mag_reg  <= mag;
            neg5_reg <= neg;
            dg5_reg  <= (orv == '0);

            for (int i = 0; i < 3; i++) begin
                sm6_reg[i] <= shifted[i][SMW-1:0];
            end
            neg6_reg <= neg5_reg;
            dg6_reg  <= dg5_reg;

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQW'(sm6_reg[i]) * SQW'(sm6_reg[i]);
            end
            sm7_reg  <= sm6_reg;
            neg7_reg <= neg6_reg;
            dg7_reg  <= dg6_reg;

            sum_reg  <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            sm8_reg  <= sm7_reg;
            neg8_reg <= neg7_reg;
            dg8_reg  <= dg7_reg;
        end
    end

    assign out_valid  = v_reg[3];
    assign rad        = {sum_reg, {SQ_PAD{1'b0}}};
    assign side.sm    = sm8_reg;
    assign side.neg   = neg8_reg;
    assign side.degen = dg8_reg;

endmodule
`default_nettype wire

[hdl/tun_sqrt.sv]
`default_nettype none
module tun_sqrt
    import tun_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RADW-1:0]   rad,
    input  wire side_t             side_in,
    output logic                   out_valid,
    output logic [ROOTW-1:0]       root,
    output side_t                  side_out
);

    logic [ROOTW-1:0]   v_reg;
    logic [ROOTW+1:0]   rem_reg  [ROOTW];
    logic [ROOTW-1:0]   root_reg [ROOTW];
    logic [RADW-1:0]    rad_reg  [ROOTW];
    side_t              side_reg [ROOTW];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        logic [ROOTW+1:0] rem_in;
        logic [ROOTW-1:0] root_in;
        logic [RADW-1:0]  rad_in;
        side_t            sd_in;
        logic             v_in;
        logic [ROOTW+1:0] rem_sh;
        logic [ROOTW+1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign sd_in   = side_in;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign sd_in   = side_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign rem_sh = {rem_in[ROOTW-1:0], rad_in[RADW-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[ROOTW-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[ROOTW-2:0], 1'b0};
                end
                rad_reg[k]  <= rad_in << 2;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign out_valid = v_reg[ROOTW-1];
    assign root      = root_reg[ROOTW-1];
    assign side_out  = side_reg[ROOTW-1];

endmodule
`default_nettype wire

[hdl/tun_div.sv]
`default_nettype none
module tun_div
    import tun_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [ROOTW-1:0]  len,
    input  wire side_t             side_in,
    output logic                   out_valid,
    output logic [2:0][Q_BITS-1:0] quo,
    output side_t                  side_out
);

    logic                     pv_reg;
    logic [2:0][NUMW-1:0]     num_reg;
    logic [ROOTW-1:0]         plen_reg;
    side_t                    pside_reg;

    logic [Q_BITS-1:0]        v_reg;
    logic [2:0][ROOTW:0]      rem_reg  [Q_BITS];
    logic [2:0][Q_BITS-1:0]   q_reg    [Q_BITS];
    logic [2:0][Q_BITS-1:0]   low_reg  [Q_BITS];
    logic [ROOTW-1:0]         len_reg  [Q_BITS];
    side_t                    side_reg [Q_BITS];

    // numerator with half the divisor added for rounding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= {1'b0, side_in.sm[i], {FRAC_SHIFT{1'b0}}}
                            + NUMW'(len >> 1);
            end
            plen_reg  <= len;
            pside_reg <= side_in;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic [2:0][ROOTW:0]    rem_in;
        logic [2:0][Q_BITS-1:0] q_in;
        logic [2:0][Q_BITS-1:0] low_in;
        logic [ROOTW-1:0]       len_in;
        side_t                  sd_in;
        logic                   v_in;
        logic [2:0][ROOTW:0]    rem_sh;

        if (k == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = (ROOTW + 1)'(num_reg[j] >> Q_BITS);
                assign low_in[j] = num_reg[j][Q_BITS-1:0];
            end
            assign q_in   = '0;
            assign len_in = plen_reg;
            assign sd_in  = pside_reg;
            assign v_in   = pv_reg;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign low_in = low_reg[k-1];
            assign len_in = len_reg[k-1];
            assign sd_in  = side_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_sh
            assign rem_sh[j] = {rem_in[j][ROOTW-1:0], low_in[j][Q_BITS-1]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_sh[i] >= (ROOTW + 1)'(len_in)) begin
                        rem_reg[k][i] <= rem_sh[i] - (ROOTW + 1)'(len_in);
                        q_reg[k][i]   <= {q_in[i][Q_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg[k][i] <= rem_sh[i];
                        q_reg[k][i]   <= {q_in[i][Q_BITS-2:0], 1'b0};
                    end
                    low_reg[k][i] <= low_in[i] << 1;
                end
                len_reg[k]  <= len_in;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign out_valid = v_reg[Q_BITS-1];
    assign quo       = q_reg[Q_BITS-1];
    assign side_out  = side_reg[Q_BITS-1];

endmodule
`default_nettype wire

[hdl/triangle_unit_normal_top.sv]
// Unit face normal of a triangle.
// Input channel s_valid/s_ready/s_data carries one triangle per beat: three
// vertices, signed Q7.16 coordinates. Output channel m_valid/m_ready/m_data
// carries one beat per triangle: the unit normal in signed Q1.14 and a
// degenerate flag, set with a zero normal when the cross product is zero.
// Results come out in input order.
// From input beat to output beat a triangle passes 4 stages of edge,
// product and cross arithmetic, 4 stages of range reduction and squaring,
// 31 square-root stages (one root bit each), 1 rounding stage, 15 divider
// stages (one quotient bit each, three lanes side by side) and the output
// register.
// One triangle per cycle unless stalled; the pipeline holds up to 56 beats.
// When m_ready is low while m_valid is high, every stage holds and s_ready
// drops in the same cycle; no input is taken until the output beat leaves,
// even when the pipeline has empty slots.
// Reset (aresetn low, synchronous) empties the pipeline; payload registers
// are not cleared.
`default_nettype none
module triangle_unit_normal_top
    import tun_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tri_in_t   s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output norm_out_t      m_data
);

    logic                 en;
    logic                 cr_valid;
    logic [2:0][MW-1:0]   cr_mag;
    logic [2:0]           cr_neg;
    logic                 sc_valid;
    logic [RADW-1:0]      sc_rad;
    side_t                sc_side;
    logic                 sq_valid;
    logic [ROOTW-1:0]     sq_root;
    side_t                sq_side;
    logic                 dv_valid;
    logic [2:0][Q_BITS-1:0] dv_quo;
    side_t                dv_side;
    logic                 out_valid_reg;
    norm_out_t            out_reg;
    norm_out_t            out_next;
    logic [OUT_W-1:0]     comp [3];

    // advance whenever the output slot is free or being taken
    assign en      = m_ready || !out_valid_reg;
    assign s_ready = en;

    tun_cross u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .din      (s_data),
        .out_valid(cr_valid),
        .mag      (cr_mag),
        .neg      (cr_neg)
    );

    tun_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cr_valid),
        .mag      (cr_mag),
        .neg      (cr_neg),
        .out_valid(sc_valid),
        .rad      (sc_rad),
        .side     (sc_side)
    );

    tun_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sc_valid),
        .rad      (sc_rad),
        .side_in  (sc_side),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side)
    );

    tun_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_valid),
        .len      (sq_root),
        .side_in  (sq_side),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // saturate to one and apply sign; zero when degenerate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [OUT_W-1:0] q;
            q = (dv_quo[i] > Q_BITS'(OUT_ONE)) ? OUT_W'(OUT_ONE) : OUT_W'(dv_quo[i]);
            if (dv_side.degen) begin
                comp[i] = '0;
            end else if (dv_side.neg[i]) begin
                comp[i] = -q;
            end else begin
                comp[i] = q;
            end
        end
        out_next.norm_x     = comp[0];
        out_next.norm_y     = comp[1];
        out_next.norm_z     = comp[2];
        out_next.degenerate = dv_side.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire
